[rtl/mtf_pkg.sv]
// Shared constants and control types for the move-to-front coder.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

    // Width of a symbol on the data channels.
    localparam int SYM_W = 8;

    // Default number of entries in the recency list.
    localparam int ALPHABET_SIZE_DEF = 256;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FRONT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // take a new transaction and read list position 0
        logic step;    // examine one list position and shift it back
        logic finish;  // write the front entry and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // the position under examination ends the scan
        logic out_free;  // the output register can take a result this cycle
    } status_t;

endpackage

`default_nettype wire

[rtl/mtf_ctrl.sv]
// Controller state machine for the move-to-front coder.
`timescale 1ns / 1ps
`default_nettype none

module mtf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mtf_pkg::status_t st,
    output mtf_pkg::cmd_t         cmd
);

    mtf_pkg::state_t state_reg;
    mtf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mtf_pkg::ST_SCAN;
                end
            end
            mtf_pkg::ST_SCAN:
            begin
                if (st.done)
                begin
                    state_next = mtf_pkg::ST_FRONT;
                end
            end
            mtf_pkg::ST_FRONT:
            begin
                if (st.out_free)
                begin
                    state_next = mtf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mtf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            mtf_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            mtf_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
            end
            mtf_pkg::ST_FRONT:
            begin
                cmd.finish = st.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/mtf_dpath.sv]
// Datapath of the move-to-front coder: recency list memory, scan registers and output register.
`timescale 1ns / 1ps
`default_nettype none

module mtf_dpath #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mtf_pkg::cmd_t            cmd,
    output mtf_pkg::status_t              st,
    input  wire logic [mtf_pkg::SYM_W-1:0] symbol_in,
    input  wire logic                     end_of_block,
    input  wire logic                     mode_in,
    input  wire logic                     out_ready,
    output logic                          out_valid,
    output logic [mtf_pkg::SYM_W-1:0]     symbol_out,
    output logic                          end_of_block_out
);

    localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam logic [IDX_W-1:0]         LAST_POS  = IDX_W'(ALPHABET_SIZE - 1);
    localparam logic [mtf_pkg::SYM_W:0]  ALPHA_LIM = (mtf_pkg::SYM_W + 1)'(ALPHABET_SIZE);

    // Recency list storage; entries without a valid bit read as the identity.
    logic [IDX_W-1:0]         mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] valid_reg;

    logic [IDX_W-1:0]          mem_q_reg;
    logic                      valid_q_reg;
    logic [mtf_pkg::SYM_W-1:0] sym_reg;
    logic                      eob_reg;
    logic                      mode_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic [IDX_W-1:0]          pos_next;
    logic [IDX_W-1:0]          carry_reg;
    logic [IDX_W-1:0]          front_val_reg;
    logic                      front_we_reg;
    logic [mtf_pkg::SYM_W-1:0] result_reg;
    logic [mtf_pkg::SYM_W-1:0] result_next;
    logic                      out_valid_reg;
    logic [mtf_pkg::SYM_W-1:0] sym_out_reg;
    logic                      eob_out_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
    logic             wr_en;
    logic [IDX_W-1:0] old_val;
    logic             in_range;
    logic             hit;
    logic             done;

    assign old_val  = valid_q_reg ? mem_q_reg : pos_reg;
    assign in_range = ({1'b0, sym_reg} < ALPHA_LIM);
    assign hit      = mode_reg ? (pos_reg == sym_reg[IDX_W-1:0])
                               : (old_val == sym_reg[IDX_W-1:0]);
    assign done     = !in_range || hit;

    assign st.done     = done;
    assign st.out_free = !out_valid_reg || out_ready;

    assign pos_next = (pos_reg == LAST_POS) ? '0 : IDX_W'(pos_reg + 1'b1);
    assign rd_addr  = cmd.step ? pos_next : '0;

    // A scan step shifts the carried entry back into the examined position;
    // the finishing cycle puts the moved symbol at the front.
    assign wr_addr = cmd.finish ? '0 : pos_reg;
    assign wr_data = cmd.finish ? front_val_reg : carry_reg;
    assign wr_en   = cmd.finish ? (front_we_reg && !eob_reg)
                                : (cmd.step && in_range && (pos_reg != '0));

    always_comb
    begin
        if (!in_range)
        begin
            result_next = sym_reg;
        end
        else if (mode_reg)
        begin
            result_next = mtf_pkg::SYM_W'(old_val);
        end
        else
        begin
            result_next = mtf_pkg::SYM_W'(pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg   <= mem[rd_addr];
        valid_q_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.finish && eob_reg)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Scan registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sym_reg  <= symbol_in;
            eob_reg  <= end_of_block;
            mode_reg <= mode_in;
            pos_reg  <= '0;
        end
        else if (cmd.step)
        begin
            carry_reg <= old_val;
            if (done)
            begin
                result_reg    <= result_next;
                front_val_reg <= old_val;
                front_we_reg  <= in_range;
            end
            else
            begin
                pos_reg <= pos_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            sym_out_reg <= result_reg;
            eob_out_reg <= eob_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign symbol_out       = sym_out_reg;
    assign end_of_block_out = eob_out_reg;

    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (pos_reg == '0))
        else $error("scan does not start at the front of the list");

    a_step_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !done) |=> (pos_reg == $past(pos_next)))
        else $error("scan position did not advance by one");

    a_front_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && cmd.step) |-> (wr_addr != '0))
        else $error("scan step wrote the front entry");

    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished transaction did not reach the output register");

    a_block_clears_list: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && eob_reg) |=> ($countones(valid_reg) == 0))
        else $error("list not returned to identity after end of block");

endmodule

`default_nettype wire

[rtl/move_to_front_transform.sv]
// Top level of the byte move-to-front coder with its configuration register.
//
// Usage: symbols enter on the input channel (in_valid/in_ready, symbol_in,
// end_of_block) and one result per input transaction leaves on the output
// channel (out_valid/out_ready, symbol_out, end_of_block_out). The APB port
// holds a single register, decode_mode, at byte address 0: 0 encodes bytes
// to ranks, 1 decodes ranks to bytes. It should only be written while no
// transaction is in flight.
// Scan: after a transaction is accepted, the scan walks the list from the
// front to position r, where r is the list position of the byte (encode) or
// the rank itself (decode); an out-of-range symbol ends the scan at position 0.
// A new transaction is taken only after the previous one has written the front
// entry and loaded its result into the output register. The scan walks the list
// memory one entry per cycle, shifting each entry back as it goes.
// Reset: decode_mode returns to 0 and the list is the identity at once,
// since every entry's valid bit is cleared; there is no clearing pass. The
// same happens to the list after a transaction that carries end_of_block.
// Stalls: when the receiver holds out_ready low, a finished result waits in
// the output register while the next transaction is taken and scanned; the
// scan then pauses before its final write until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_transform #(
    parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Input channel
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mtf_pkg::SYM_W-1:0]   symbol_in,
    input  wire logic                        end_of_block,
    // Output channel
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mtf_pkg::SYM_W-1:0]        symbol_out,
    output logic                             end_of_block_out,
    // Configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mtf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [mtf_pkg::PDATA_W-1:0] pwdata,
    output logic [mtf_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    // Word index of the decode_mode register (byte address divided by four).
    localparam logic REG_DECODE_MODE = 1'b0;

    logic             decode_mode_reg;
    logic             decode_mode_next;
    logic             reg_sel;
    logic             reg_write;
    mtf_pkg::cmd_t    cmd;
    mtf_pkg::status_t st;

    // The register is word-addressed; the two low address bits are ignored.
    assign reg_sel   = (paddr[2] == REG_DECODE_MODE);
    assign reg_write = psel && penable && pwrite && pready && reg_sel;
    assign pready    = 1'b1;

    assign decode_mode_next = reg_write ? pwdata[0] : decode_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
        end
        else
        begin
            decode_mode_reg <= decode_mode_next;
        end
    end

    // Reads return the register in bit 0; unused addresses read as zero.
    assign prdata = reg_sel ? {{(mtf_pkg::PDATA_W - 1){1'b0}}, decode_mode_reg} : '0;

    // The controller sequences each transaction through scan and front write.
    mtf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // The datapath holds the list, the scan registers and the output register.
    mtf_dpath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .symbol_in        (symbol_in),
        .end_of_block     (end_of_block),
        .mode_in          (decode_mode_reg),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .symbol_out       (symbol_out),
        .end_of_block_out (end_of_block_out)
    );

endmodule

`default_nettype wire
